### hw/rtl/protein_cleavage_digester_macros.svh
// Assertion macros for the cleavage digester.
`ifndef PROTEIN_CLEAVAGE_DIGESTER_MACROS_SVH
`define PROTEIN_CLEAVAGE_DIGESTER_MACROS_SVH

`ifndef SYNTH
`define PCD_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("pcd: invariant violated");
`define PCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcd: next-cycle check failed");
`else
`define PCD_ASSERT_ALWAYS(label, clk, rst, cond)
`define PCD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### hw/rtl/pcd_pkg.sv
package pcd_pkg;

   localparam int RES_W      = 8;
   localparam int IDX_W      = 16;
   localparam int MASK_W     = 26;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 26;

   localparam int MAX_PROTEIN_LEN = 65535;
   localparam logic [IDX_W-1:0] LAST_POSITION = IDX_W'(MAX_PROTEIN_LEN - 1);

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   localparam logic [RES_W-1:0] TERMINAL_MARK = 8'h2A;  // '*'
   localparam logic [RES_W-1:0] CHAR_A = 8'h41;
   localparam logic [RES_W-1:0] CHAR_B = 8'h42;
   localparam logic [RES_W-1:0] CHAR_I = 8'h49;
   localparam logic [RES_W-1:0] CHAR_J = 8'h4A;
   localparam logic [RES_W-1:0] CHAR_L = 8'h4C;
   localparam logic [RES_W-1:0] CHAR_O = 8'h4F;
   localparam logic [RES_W-1:0] CHAR_U = 8'h55;
   localparam logic [RES_W-1:0] CHAR_X = 8'h58;
   localparam logic [RES_W-1:0] CHAR_Z = 8'h5A;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NTERM_MASK,
      CSR_CTERM_MASK,
      CSR_MERGE_LEU,
      CSR_MIN_LEN,
      CSR_MAX_LEN
   } csr_index_type;

   typedef struct packed {
      logic [RES_W-1:0] residue;
      logic             final_residue;
   } req_payload_type;

   typedef struct packed {
      logic [IDX_W-1:0] start_index;
      logic [IDX_W-1:0] end_index;
      logic [IDX_W-1:0] peptide_length;
      logic [RES_W-1:0] prev_residue;
      logic [RES_W-1:0] first_residue;
      logic [RES_W-1:0] last_residue;
      logic [RES_W-1:0] post_residue;
      logic             kept;
      logic             protein_done;
   } rsp_payload_type;

   typedef struct packed {
      logic [IDX_W-1:0] start;
      logic [IDX_W-1:0] length;
      logic [RES_W-1:0] prev;
      logic [RES_W-1:0] first;
      logic [RES_W-1:0] last;
      logic             invalid;
   } peptide_type;

   localparam peptide_type CLEAR_PEPTIDE = '{
      start: '0, length: '0, prev: TERMINAL_MARK, first: '0, last: '0, invalid: 1'b0
   };

   function automatic logic is_bad_letter(input logic [RES_W-1:0] aa);
      return (aa == CHAR_B) || (aa == CHAR_J) || (aa == CHAR_O) ||
             (aa == CHAR_U) || (aa == CHAR_Z);
   endfunction

   function automatic rsp_payload_type make_rsp(
      input peptide_type      rec,
      input logic [RES_W-1:0] post,
      input logic             done,
      input logic [IDX_W-1:0] min_len,
      input logic [IDX_W-1:0] max_len
   );
      rsp_payload_type r;
      r.start_index    = rec.start;
      r.end_index      = IDX_W'(rec.start + rec.length - 1'b1);
      r.peptide_length = rec.length;
      r.prev_residue   = rec.prev;
      r.first_residue  = rec.first;
      r.last_residue   = rec.last;
      r.post_residue   = post;
      r.kept           = (rec.length >= min_len) && (rec.length <= max_len) && !rec.invalid;
      r.protein_done   = done;
      return r;
   endfunction

endpackage

### hw/rtl/pcd_req_if.sv
interface pcd_req_if;
   import pcd_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/pcd_rsp_if.sv
interface pcd_rsp_if;
   import pcd_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/protein_cleavage_digester.sv
// Path: the input register, then the 4-entry result FIFO, then rsp_chan.
// Throughput: one residue per cycle while each residue closes at most one peptide and
//   rsp_chan is ready; a residue is taken only while the FIFO has room for two records,
//   and the records of a residue that closes two are drained by the single-record output port.
// Reset: synchronous, active high; clears the stream state and FIFO and loads
//   register defaults (masks 0, merge off, min 0, max 65535).
`include "protein_cleavage_digester_macros.svh"

module protein_cleavage_digester (
   input  logic                           clock,
   input  logic                           reset,
   pcd_req_if.sink                        req_chan,
   pcd_rsp_if.source                      rsp_chan,
   input  logic                           csr_write_en,
   input  logic [pcd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pcd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pcd_pkg::*;

   // ---------------------------------------------------------------- config
   logic [MASK_W-1:0] nterm_mask_ff;
   logic [MASK_W-1:0] cterm_mask_ff;
   logic              merge_ff;
   logic [IDX_W-1:0]  min_len_ff;
   logic [IDX_W-1:0]  max_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         nterm_mask_ff <= '0;
         cterm_mask_ff <= '0;
         merge_ff      <= 1'b0;
         min_len_ff    <= '0;
         max_len_ff    <= '1;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_NTERM_MASK: nterm_mask_ff <= csr_wdata[MASK_W-1:0];
            CSR_CTERM_MASK: cterm_mask_ff <= csr_wdata[MASK_W-1:0];
            CSR_MERGE_LEU:  merge_ff      <= csr_wdata[0];
            CSR_MIN_LEN:    min_len_ff    <= csr_wdata[IDX_W-1:0];
            CSR_MAX_LEN:    max_len_ff    <= csr_wdata[IDX_W-1:0];
            default:        ;  // unmapped index: ignored
         endcase
      end
   end

   // ---------------------------------------------------------------- input register
   logic             in_valid_ff, in_valid_in;
   req_payload_type  in_data_ff;
   logic             fire;

   assign req_chan.ready = !in_valid_ff || fire;
   assign in_valid_in    = req_chan.ready ? req_chan.valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_data_ff <= req_chan.payload;
      end
   end

   // ---------------------------------------------------------------- stream state
   logic [IDX_W-1:0] position_ff, position_in;
   logic [RES_W-1:0] prior_ff, prior_in;
   peptide_type      open_ff, open_in;
   peptide_type      held_ff, held_in;
   logic             held_valid_ff, held_valid_in;

   // ---------------------------------------------------------------- residue decode
   logic [RES_W-1:0] residue_m;     // after L/I merge
   logic             is_letter;
   logic [4:0]       letter_idx;
   logic             nt_hit, ct_hit;
   logic             is_last;
   logic             close_before;  // N-terminal cut with a non-empty open peptide
   logic             to_hold;       // C-terminal cut: park record until post residue

   always_comb begin
      residue_m = in_data_ff.residue;
      if (merge_ff && (in_data_ff.residue == CHAR_L || in_data_ff.residue == CHAR_I)) begin
         residue_m = CHAR_X;
      end
   end

   assign is_letter    = (residue_m >= CHAR_A) && (residue_m <= CHAR_Z);
   assign letter_idx   = 5'(residue_m - CHAR_A);
   assign nt_hit       = is_letter && nterm_mask_ff[letter_idx];
   assign ct_hit       = is_letter && cterm_mask_ff[letter_idx];
   // overlong proteins are cut off after MAX_PROTEIN_LEN residues (at position LAST_POSITION)
   assign is_last      = in_data_ff.final_residue || (position_ff >= LAST_POSITION);
   assign close_before = nt_hit && (open_ff.length != '0);
   assign to_hold      = ct_hit && !nt_hit && !is_last;

   // ---------------------------------------------------------------- peptide update
   peptide_type base_rec, grown_rec;
   peptide_type rec_a;      // held record, or peptide closed before this residue
   logic        rec_a_valid;

   always_comb begin
      base_rec = open_ff;
      if (close_before) begin
         base_rec.length  = '0;
         base_rec.invalid = 1'b0;
      end
      grown_rec = base_rec;
      if (base_rec.length == '0) begin
         grown_rec.start   = position_ff;
         grown_rec.first   = residue_m;
         grown_rec.prev    = prior_ff;
         grown_rec.invalid = 1'b0;
      end
      grown_rec.length = IDX_W'(base_rec.length + 1'b1);
      grown_rec.last   = residue_m;
      if (is_bad_letter(residue_m)) begin
         grown_rec.invalid = 1'b1;
      end
   end

   // A held record always leaves the open peptide empty, so a held record and an
   // N-terminal close never coincide: at most two records per residue.
   assign rec_a       = held_valid_ff ? held_ff : open_ff;
   assign rec_a_valid = held_valid_ff || close_before;

   always_comb begin
      position_in   = position_ff;
      prior_in      = prior_ff;
      open_in       = open_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      if (fire) begin
         if (is_last) begin
            position_in   = '0;
            prior_in      = TERMINAL_MARK;
            open_in       = CLEAR_PEPTIDE;
            held_in       = CLEAR_PEPTIDE;
            held_valid_in = 1'b0;
         end else begin
            position_in   = IDX_W'(position_ff + 1'b1);
            prior_in      = residue_m;
            open_in       = grown_rec;
            held_valid_in = to_hold;
            if (to_hold) begin
               held_in         = grown_rec;
               open_in.length  = '0;
               open_in.invalid = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= '0;
         prior_ff      <= TERMINAL_MARK;
         open_ff       <= CLEAR_PEPTIDE;
         held_ff       <= CLEAR_PEPTIDE;
         held_valid_ff <= 1'b0;
      end else begin
         position_ff   <= position_in;
         prior_ff      <= prior_in;
         open_ff       <= open_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
      end
   end

   // ---------------------------------------------------------------- result FIFO
   rsp_payload_type              fifo_ff [FIFO_DEPTH];
   rsp_payload_type              fifo_in [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]        cnt_ff, cnt_in;
   logic [FIFO_PTR_W-1:0]        wr_ptr_nx;
   logic [1:0]                   push_cnt;
   logic                         pop;
   rsp_payload_type              rsp_a, rsp_b, entry0;

   // process only with room for two records, whatever this residue produces
   assign fire = in_valid_ff && (cnt_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));

   assign rsp_a  = make_rsp(rec_a, residue_m, 1'b0, min_len_ff, max_len_ff);
   assign rsp_b  = make_rsp(grown_rec, TERMINAL_MARK, 1'b1, min_len_ff, max_len_ff);
   assign entry0 = rec_a_valid ? rsp_a : rsp_b;

   assign push_cnt  = fire ? (2'(rec_a_valid) + 2'(is_last)) : 2'd0;
   assign pop       = rsp_chan.valid && rsp_chan.ready;
   assign wr_ptr_nx = FIFO_PTR_W'(wr_ptr_ff + 1'b1);

   always_comb begin
      for (int i = 0; i < FIFO_DEPTH; i++) begin
         fifo_in[i] = fifo_ff[i];
         if ((push_cnt != 2'd0) && (FIFO_PTR_W'(i) == wr_ptr_ff)) begin
            fifo_in[i] = entry0;
         end
         if ((push_cnt == 2'd2) && (FIFO_PTR_W'(i) == wr_ptr_nx)) begin
            fifo_in[i] = rsp_b;
         end
      end
   end

   assign wr_ptr_in = FIFO_PTR_W'(wr_ptr_ff + push_cnt);
   assign rd_ptr_in = FIFO_PTR_W'(rd_ptr_ff + pop);
   assign cnt_in    = FIFO_CNT_W'(cnt_ff + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop));

   always_ff @(posedge clock) begin
      fifo_ff <= fifo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   assign rsp_chan.valid   = (cnt_ff != '0);
   assign rsp_chan.payload = fifo_ff[rd_ptr_ff];

   // ---------------------------------------------------------------- checks
   `PCD_ASSERT_ALWAYS(a_fifo_bound, clock, reset, cnt_ff <= FIFO_CNT_W'(FIFO_DEPTH))
   `PCD_ASSERT_ALWAYS(a_held_empty_open, clock, reset, !held_valid_ff || (open_ff.length == '0))
   `PCD_ASSERT_NEXT(a_end_clears, clock, reset, fire && is_last, (position_ff == '0) && !held_valid_ff && (open_ff.length == '0))

endmodule
